[design/ps2md_pkg.sv]
`default_nettype none
package ps2md_pkg;

  localparam int POS_BITS_DEFAULT = 16;
  localparam int OUT_POS_W        = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [15:0] DEFAULT_W = 16'd800;
  localparam logic [15:0] DEFAULT_H = 16'd600;
  localparam logic [15:0] RESET_X   = 16'd400;
  localparam logic [15:0] RESET_Y   = 16'd300;

  localparam logic [7:0] SYNC_BIT  = 8'h08;
  localparam logic [7:0] XSIGN_BIT = 8'h10;
  localparam logic [7:0] YSIGN_BIT = 8'h20;
  localparam logic [7:0] BTN_MASK  = 8'h03;

  localparam logic [1:0] EV_MOVE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [OUT_POS_W-1:0] pos_x;
    logic [OUT_POS_W-1:0] pos_y;
    logic [1:0]           changed;
    logic [1:0]           buttons;
  } packet_rec_t;

endpackage
`default_nettype wire

[design/ps2md_front.sv]
`default_nettype none
module ps2md_front
  import ps2md_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  mouse_byte,
  input  wire logic [15:0] screen_width,
  input  wire logic [15:0] screen_height,
  input  wire logic        q_full,
  output logic             q_push,
  output packet_rec_t      q_data
);

  localparam int P     = POSITION_BITS;
  localparam int SUM_W = P + 2;

  localparam logic [1:0] PH_FLAGS = 2'd0;
  localparam logic [1:0] PH_X     = 2'd1;
  localparam logic [1:0] PH_Y     = 2'd2;

  logic [1:0]   phase;
  logic [7:0]   flags_byte;
  logic [7:0]   x_byte;
  logic [P-1:0] pointer_x;
  logic [P-1:0] pointer_y;
  logic [1:0]   button_bits;

  logic             accept;
  logic             last_byte;
  logic signed [8:0] dx;
  logic signed [8:0] dy;
  logic signed [SUM_W-1:0] x_sum;
  logic signed [SUM_W-1:0] y_sum;
  logic [P-1:0]     pointer_x_next;
  logic [P-1:0]     pointer_y_next;
  logic [1:0]       new_btn;

  function automatic logic [P-1:0] clamp_axis(logic signed [SUM_W-1:0] v,
                                               logic [15:0] size,
                                               logic [15:0] dflt);
    logic [16:0]      s;
    logic [SUM_W-1:0] lim;
    logic [SUM_W-1:0] lim_m1;
    logic [P-1:0]     r;
    s = (size == 16'd0) ? {1'b0, dflt} : {1'b0, size};
    if (s > (17'd1 << P)) s = 17'd1 << P;
    lim    = SUM_W'(s);
    lim_m1 = lim - SUM_W'(1);
    if (v[SUM_W-1]) r = '0;
    else if ($unsigned(v) >= lim) r = lim_m1[P-1:0];
    else r = v[P-1:0];
    return r;
  endfunction

  assign last_byte = (phase != PH_FLAGS) && (phase != PH_X);
  assign in_ready  = !last_byte || !q_full;
  assign accept    = in_valid && in_ready;

  assign dx = $signed({(flags_byte & XSIGN_BIT) != 8'd0, x_byte});
  assign dy = $signed({(flags_byte & YSIGN_BIT) != 8'd0, mouse_byte});
  assign x_sum = $signed({2'b00, pointer_x}) + {{(SUM_W-9){dx[8]}}, dx};
  assign y_sum = $signed({2'b00, pointer_y}) - {{(SUM_W-9){dy[8]}}, dy};
  assign pointer_x_next = clamp_axis(x_sum, screen_width, DEFAULT_W);
  assign pointer_y_next = clamp_axis(y_sum, screen_height, DEFAULT_H);
  assign new_btn = flags_byte[1:0] & BTN_MASK[1:0];

  assign q_push          = accept && last_byte;
  assign q_data.pos_x    = OUT_POS_W'(pointer_x_next);
  assign q_data.pos_y    = OUT_POS_W'(pointer_y_next);
  assign q_data.changed  = new_btn ^ button_bits;
  assign q_data.buttons  = new_btn;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FLAGS;
      pointer_x   <= P'(RESET_X);
      pointer_y   <= P'(RESET_Y);
      button_bits <= 2'b00;
    end else if (accept) begin
      case (phase)
        PH_FLAGS: begin
          if ((mouse_byte & SYNC_BIT) != 8'd0) phase <= PH_X;
        end
        PH_X: begin
          phase <= PH_Y;
        end
        default: begin
          phase       <= PH_FLAGS;
          pointer_x   <= pointer_x_next;
          pointer_y   <= pointer_y_next;
          button_bits <= new_btn;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_FLAGS) flags_byte <= mouse_byte;
    if (accept && phase == PH_X) x_byte <= mouse_byte;
  end

endmodule
`default_nettype wire

[design/ps2md_queue.sv]
`default_nettype none
module ps2md_queue
  import ps2md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire packet_rec_t push_data,
  output logic             full,
  input  wire logic        pop,
  output logic             head_valid,
  output packet_rec_t      head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  packet_rec_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

[design/ps2md_back.sv]
`default_nettype none
module ps2md_back
  import ps2md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire packet_rec_t head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_kind,
  output logic             button_index,
  output logic [15:0]      pos_x,
  output logic [15:0]      pos_y,
  output logic             last_event
);

  localparam logic [1:0] STG_MOVE   = 2'd0;
  localparam logic [1:0] STG_FIRST  = 2'd1;
  localparam logic [1:0] STG_SECOND = 2'd2;

  logic [1:0] stage;
  logic       load;
  logic       emit;
  logic [1:0] ev_kind;
  logic       ev_idx;
  logic       ev_last;

  always_comb begin
    case (stage)
      STG_MOVE: begin
        ev_idx  = 1'b0;
        ev_kind = EV_MOVE;
        ev_last = (head.changed == 2'b00);
      end
      STG_FIRST: begin
        ev_idx  = !head.changed[0];
        ev_kind = head.buttons[ev_idx] ? EV_PRESS : EV_RELEASE;
        ev_last = (head.changed != 2'b11);
      end
      default: begin
        ev_idx  = 1'b1;
        ev_kind = head.buttons[1] ? EV_PRESS : EV_RELEASE;
        ev_last = 1'b1;
      end
    endcase
  end

  assign load = !out_valid || out_ready;
  assign emit = load && head_valid;
  assign pop  = emit && ev_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      stage     <= STG_MOVE;
    end else begin
      if (load) out_valid <= head_valid;
      if (emit) stage <= ev_last ? STG_MOVE : stage + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind   <= ev_kind;
      button_index <= ev_idx;
      pos_x        <= head.pos_x;
      pos_y        <= head.pos_y;
      last_event   <= ev_last;
    end
  end

  a_second_needs_both: assert property (@(posedge clk) disable iff (rst)
    (head_valid && stage == STG_SECOND) |-> (head.changed == 2'b11))
    else $error("second button beat without both buttons changed");

  a_move_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_MOVE) |-> (button_index == 1'b0))
    else $error("move beat carries a button index");

  a_stage_holds_record: assert property (@(posedge clk) disable iff (rst)
    (stage != STG_MOVE) |-> head_valid)
    else $error("packet record left the queue before its last beat");

  a_pop_resets_stage: assert property (@(posedge clk) disable iff (rst)
    pop |=> (stage == STG_MOVE))
    else $error("stage not back to move after last beat");

endmodule
`default_nettype wire

[design/ps2_mouse_packet_decoder.sv]
// Third byte taken: record queued, then move beat registered. One byte per cycle
// while in_ready; one event beat per cycle unless stalled, up to 3 per packet.
// A two-entry packet queue between decoder and event sequencer absorbs bursts.
// Reset (rst, synchronous): phase 0, pointer 400/300, buttons clear, queue empty,
// screen size registers back to 800 by 600.
`default_nettype none
module ps2_mouse_packet_decoder
  import ps2md_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  mouse_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_kind,
  output logic             button_index,
  output logic [15:0]      pos_x,
  output logic [15:0]      pos_y,
  output logic             last_event
);

  logic [15:0] screen_width;
  logic [15:0] screen_height;
  logic        cfg_wr;

  logic        q_full;
  logic        q_push;
  packet_rec_t q_data;
  logic        q_pop;
  logic        q_head_valid;
  packet_rec_t q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {16'd0, screen_height} : {16'd0, screen_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DEFAULT_W;
      screen_height <= DEFAULT_H;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) screen_width <= pwdata[15:0];
      else screen_height <= pwdata[15:0];
    end
  end

  ps2md_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mouse_byte   (mouse_byte),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  ps2md_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head      (q_head)
  );

  ps2md_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .button_index(button_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .last_event  (last_event)
  );

endmodule
`default_nettype wire
